// File: rtl/bfsr_pkg.sv
package bfsr_pkg;

	localparam int STORE_BYTES_DEF    = 4096;
	localparam int MAX_FIELD_BITS_DEF = 64;
	localparam int VALUE_W            = 64;
	localparam int COUNT_W            = 16;

	typedef enum logic [3:0] {
		CMD_APPEND    = 4'd0,
		CMD_READ_U    = 4'd1,
		CMD_READ_S    = 4'd2,
		CMD_READ_RUN  = 4'd3,
		CMD_SKIP      = 4'd4,
		CMD_PEEK      = 4'd5,
		CMD_MARK      = 4'd6,
		CMD_REW_MARK  = 4'd7,
		CMD_REW_START = 4'd8,
		CMD_CLEAR     = 4'd9
	} cmd_e;

	typedef enum logic [1:0] {
		FMT_SIGN_MAG = 2'd0,
		FMT_ONES     = 2'd1,
		FMT_TWOS     = 2'd2,
		FMT_INVALID  = 2'd3
	} fmt_e;

	typedef struct packed {
		logic [3:0]         command;
		logic [7:0]         data_byte;
		logic [COUNT_W-1:0] bit_count;
		logic [1:0]         sign_format;
	} cmd_item_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
		logic               run_bit;
		logic [COUNT_W-1:0] run_length;
		logic [COUNT_W-1:0] rewound_bits;
		logic [COUNT_W-1:0] cursor_position;
		logic [COUNT_W-1:0] remaining_bits;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic check;
		logic app_lo;
		logic fetch_field;
		logic extract;
		logic convert;
		logic fetch_run;
		logic load_out;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic go_field;
		logic go_run;
		logic go_lo;
		logic field_last;
		logic run_last;
	} st_t;

endpackage

// File: rtl/bfsr_ctrl.sv
module bfsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  bfsr_pkg::st_t  st,
	output bfsr_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_APP_LO,
		S_FIELD,
		S_EXTRACT,
		S_CONVERT,
		S_RUN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   load_out;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	// the output register frees up in the same cycle it is taken
	assign load_out  = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		ctl             = '0;
		ctl.accept      = cmd_valid && cmd_ready;
		ctl.check       = (state_q == S_CHECK);
		ctl.app_lo      = (state_q == S_APP_LO);
		ctl.fetch_field = (state_q == S_FIELD);
		ctl.extract     = (state_q == S_EXTRACT);
		ctl.convert     = (state_q == S_CONVERT);
		ctl.fetch_run   = (state_q == S_RUN);
		ctl.load_out    = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (st.go_field)     state_q <= S_FIELD;
					else if (st.go_run)  state_q <= S_RUN;
					else if (st.go_lo)   state_q <= S_APP_LO;
					else                 state_q <= S_FINISH;
				end
				S_APP_LO:  state_q <= S_FINISH;
				S_FIELD: begin
					if (st.field_last) state_q <= S_EXTRACT;
				end
				S_EXTRACT: state_q <= S_CONVERT;
				S_CONVERT: state_q <= S_FINISH;
				S_RUN: begin
					if (st.run_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/bfsr_dp.sv
module bfsr_dp #(
	parameter int STORE_BYTES    = bfsr_pkg::STORE_BYTES_DEF,
	parameter int MAX_FIELD_BITS = bfsr_pkg::MAX_FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfsr_pkg::cmd_item_t   cmd,
	input  bfsr_pkg::ctl_t        ctl,
	output bfsr_pkg::st_t         st,
	output bfsr_pkg::rsp_item_t   rsp
);

	localparam int CAP_BITS = STORE_BYTES * 8;
	localparam int LEN_W    = $clog2(CAP_BITS + 1);
	localparam int ADDR_W   = $clog2(STORE_BYTES);
	localparam int CW       = bfsr_pkg::COUNT_W;
	localparam int VW       = bfsr_pkg::VALUE_W;
	localparam int CMP_W    = (LEN_W > CW) ? LEN_W : CW;

	logic [7:0] mem [STORE_BYTES];

	bfsr_pkg::cmd_item_t item_q;
	bfsr_pkg::rsp_item_t rsp_q;
	logic [LEN_W-1:0]  len_q, cur_q, mark_q, pos_q, rew_q;
	logic [7:0]        tail_q, lo_byte_q, rd_data_q;
	logic [ADDR_W-1:0] lo_addr_q, addr_q;
	logic [3:0]        issue_left_q, recv_left_q;
	logic              rvalid_q, first_q;
	logic [71:0]       acc_q;
	logic [6:0]        nf_q;
	logic [2:0]        t_q;
	logic [VW-1:0]     raw_q, val_q;
	logic              ok_q, rbit_q;
	logic [CW-1:0]     run_q;

	bfsr_pkg::cmd_e cmd_code;
	bfsr_pkg::fmt_e fmt;
	logic [LEN_W-1:0]  rem;
	logic [CMP_W-1:0]  n_ext, rem_ext, free_ext;
	logic              pre_ok, go_field, go_run, go_lo, app_write;
	logic [2:0]        app_off, cur_off;
	logic [15:0]       comb16;
	logic [3:0]        app_end;
	logic [6:0]        nf;
	logic [7:0]        fsum, fsum_neg;

	assign cmd_code = bfsr_pkg::cmd_e'(item_q.command);
	assign fmt      = bfsr_pkg::fmt_e'(item_q.sign_format);
	assign rem      = len_q - cur_q;
	assign n_ext    = CMP_W'(item_q.bit_count);
	assign rem_ext  = CMP_W'(rem);
	assign free_ext = CMP_W'(LEN_W'(CAP_BITS) - len_q);
	assign app_off  = len_q[2:0];
	assign cur_off  = cur_q[2:0];
	// keep the valid bits of the partial tail byte, drop the new bits in below them
	assign comb16   = {tail_q & ~(8'hFF >> app_off), 8'h00}
	                | ({item_q.data_byte, 8'h00} >> app_off);
	assign app_end  = 4'(app_off) + item_q.bit_count[3:0];
	assign nf       = (cmd_code == bfsr_pkg::CMD_PEEK) ? 7'd1 : item_q.bit_count[6:0];
	assign fsum     = 8'(cur_off) + 8'(nf);
	assign fsum_neg = 8'd0 - fsum;

	always_comb begin
		pre_ok    = 1'b0;
		go_field  = 1'b0;
		go_run    = 1'b0;
		go_lo     = 1'b0;
		app_write = 1'b0;
		case (cmd_code)
			bfsr_pkg::CMD_APPEND: begin
				pre_ok    = (n_ext == '0) || (n_ext <= CMP_W'(8) && n_ext <= free_ext);
				app_write = pre_ok && (n_ext != '0);
				go_lo     = app_write && (app_end > 4'd8);
			end
			bfsr_pkg::CMD_READ_U: begin
				pre_ok   = (n_ext == '0) ||
				           (n_ext <= CMP_W'(MAX_FIELD_BITS) && n_ext <= rem_ext);
				go_field = pre_ok && (n_ext != '0);
			end
			bfsr_pkg::CMD_READ_S: begin
				pre_ok   = (n_ext >= CMP_W'(2)) && (n_ext <= CMP_W'(MAX_FIELD_BITS)) &&
				           (n_ext <= rem_ext) && (fmt != bfsr_pkg::FMT_INVALID);
				go_field = pre_ok;
			end
			bfsr_pkg::CMD_READ_RUN: begin
				pre_ok = (n_ext != '0) && (rem != '0);
				go_run = pre_ok;
			end
			bfsr_pkg::CMD_SKIP:      pre_ok = (n_ext <= rem_ext);
			bfsr_pkg::CMD_PEEK: begin
				pre_ok   = (rem != '0);
				go_field = pre_ok;
			end
			bfsr_pkg::CMD_MARK,
			bfsr_pkg::CMD_REW_MARK,
			bfsr_pkg::CMD_REW_START,
			bfsr_pkg::CMD_CLEAR:     pre_ok = 1'b1;
			default:                 pre_ok = 1'b0;
		endcase
	end

	// field extraction and sign conversion
	logic [71:0]   acc_sh;
	logic [VW-1:0] raw_c, top, low, neg_src, conv;
	logic          sign;

	assign acc_sh  = acc_q >> t_q;
	assign raw_c   = acc_sh[VW-1:0] & ~({VW{1'b1}} << nf_q);
	assign top     = VW'(1) << (nf_q - 7'd1);
	assign low     = top - VW'(1);
	assign sign    = |(raw_q & top);
	assign neg_src = (fmt == bfsr_pkg::FMT_SIGN_MAG) ? (raw_q & low) : (~raw_q & low);

	always_comb begin
		if (!sign) begin
			conv = raw_q;
		end else if (fmt == bfsr_pkg::FMT_TWOS) begin
			conv = raw_q | ~(low | top);
		end else begin
			conv = VW'(0) - neg_src;
		end
	end

	// run scan over one byte
	logic [2:0]       roff;
	logic [7:0]       rbyte, rx;
	logic             rb;
	logic [3:0]       lz, avail, lim_c, len_c, cap, take;
	logic [CW-1:0]    lim_left;
	logic [LEN_W-1:0] len_left;
	logic             run_last;

	assign roff     = pos_q[2:0];
	assign rbyte    = rd_data_q << roff;
	assign rb       = first_q ? rbyte[7] : rbit_q;
	assign rx       = rbyte ^ {8{rb}};
	assign avail    = 4'd8 - 4'(roff);
	assign lim_left = item_q.bit_count - run_q;
	assign len_left = len_q - pos_q;
	assign lim_c    = (lim_left < CW'(avail)) ? lim_left[3:0] : avail;
	assign len_c    = (len_left < LEN_W'(avail)) ? len_left[3:0] : avail;
	assign cap      = (lim_c < len_c) ? lim_c : len_c;
	assign take     = (lz < cap) ? lz : cap;
	assign run_last = (take != avail) || (CW'(take) == lim_left) ||
	                  (LEN_W'(take) == len_left);

	always_comb begin
		lz = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (rx[i]) lz = 4'(7 - i);
		end
	end

	assign st.go_field   = go_field;
	assign st.go_run     = go_run;
	assign st.go_lo      = go_lo;
	assign st.field_last = rvalid_q && (recv_left_q == 4'd1);
	assign st.run_last   = rvalid_q && run_last;

	// single write port, registered read port
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;

	assign we    = (ctl.check && app_write) || ctl.app_lo;
	assign waddr = ctl.app_lo ? lo_addr_q : ADDR_W'(len_q >> 3);
	assign wdata = ctl.app_lo ? lo_byte_q : comb16[15:8];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_q <= mem[addr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) item_q <= cmd;
		if (ctl.check) begin
			ok_q      <= pre_ok;
			val_q     <= '0;
			rbit_q    <= 1'b0;
			run_q     <= '0;
			rew_q     <= (cmd_code == bfsr_pkg::CMD_REW_MARK) ? cur_q - mark_q : '0;
			first_q   <= 1'b1;
			pos_q     <= cur_q;
			addr_q    <= ADDR_W'(cur_q >> 3);
			acc_q     <= '0;
			nf_q      <= nf;
			t_q       <= fsum_neg[2:0];
			lo_byte_q <= comb16[7:0];
			lo_addr_q <= ADDR_W'(len_q >> 3) + ADDR_W'(1);
			if (app_write) tail_q <= (app_end >= 4'd8) ? comb16[7:0] : comb16[15:8];
		end
		if (ctl.fetch_field) begin
			if (issue_left_q != '0) addr_q <= addr_q + ADDR_W'(1);
			if (rvalid_q) acc_q <= {acc_q[63:0], rd_data_q};
		end
		if (ctl.extract) raw_q <= raw_c;
		if (ctl.convert) begin
			if (cmd_code == bfsr_pkg::CMD_PEEK) begin
				rbit_q <= raw_q[0];
			end else if (cmd_code == bfsr_pkg::CMD_READ_S) begin
				val_q <= conv;
			end else begin
				val_q <= raw_q;
			end
		end
		if (ctl.fetch_run) begin
			addr_q <= addr_q + ADDR_W'(1);
			if (rvalid_q) begin
				first_q <= 1'b0;
				rbit_q  <= rb;
				run_q   <= run_q + CW'(take);
				pos_q   <= pos_q + LEN_W'(take);
			end
		end
		if (ctl.load_out) begin
			rsp_q.ok              <= ok_q;
			rsp_q.value           <= val_q;
			rsp_q.run_bit         <= rbit_q;
			rsp_q.run_length      <= run_q;
			rsp_q.rewound_bits    <= CW'(rew_q);
			rsp_q.cursor_position <= CW'(cur_q);
			rsp_q.remaining_bits  <= CW'(len_q - cur_q);
		end
	end

	assign rsp = rsp_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			cur_q        <= '0;
			mark_q       <= '0;
			issue_left_q <= '0;
			recv_left_q  <= '0;
			rvalid_q     <= 1'b0;
		end else begin
			rvalid_q <= (ctl.fetch_field && issue_left_q != '0) || ctl.fetch_run;
			if (ctl.check) begin
				issue_left_q <= fsum_neg[2:0] == 3'd0 ? 4'(fsum >> 3) : 4'((fsum >> 3) + 8'd1);
				recv_left_q  <= fsum_neg[2:0] == 3'd0 ? 4'(fsum >> 3) : 4'((fsum >> 3) + 8'd1);
				if (pre_ok) begin
					case (cmd_code)
						bfsr_pkg::CMD_APPEND:
							len_q <= len_q + LEN_W'(item_q.bit_count);
						bfsr_pkg::CMD_SKIP:
							cur_q <= cur_q + LEN_W'(item_q.bit_count);
						bfsr_pkg::CMD_MARK:
							mark_q <= cur_q;
						bfsr_pkg::CMD_REW_MARK:
							cur_q <= mark_q;
						bfsr_pkg::CMD_REW_START: begin
							cur_q  <= '0;
							mark_q <= '0;
						end
						bfsr_pkg::CMD_CLEAR: begin
							len_q  <= '0;
							cur_q  <= '0;
							mark_q <= '0;
						end
						default: ;
					endcase
				end
			end
			if (ctl.fetch_field) begin
				if (issue_left_q != '0) issue_left_q <= issue_left_q - 4'd1;
				if (rvalid_q) recv_left_q <= recv_left_q - 4'd1;
			end
			if (ctl.convert && cmd_code != bfsr_pkg::CMD_PEEK) begin
				cur_q <= cur_q + LEN_W'(nf_q);
			end
			if (ctl.fetch_run) begin
				if (rvalid_q && run_last) cur_q <= pos_q + LEN_W'(take);
			end
		end
	end

	a_cur_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor beyond stored bits");

	a_mark_behind_cur: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= cur_q) else $error("mark ahead of cursor");

	a_len_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAP_BITS)) else $error("stored length beyond capacity");

	a_run_take: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fetch_run && rvalid_q && first_q) |-> (take != 4'd0))
		else $error("run read consumed no bit on its first byte");

endmodule

// File: rtl/bit_field_stream_reader_core.sv
// MSB-first bit store with a read cursor and a mark. Each command beat gives exactly one
// response beat. Appends, skips, marks, rewinds and clears go from accept through a check
// state to a finish state; appends that cross a byte boundary add a state for the second
// byte write. Field reads and peeks fetch one stored byte per cycle through the single read
// port, ceil((o+n)/8) bytes for a field of n bits at bit offset o, then extract and convert
// it before the response. Run reads scan one byte per cycle. The store is not cleared at
// reset; only bits below the stored length are ever read.
module bit_field_stream_reader_core #(
	parameter int STORE_BYTES    = bfsr_pkg::STORE_BYTES_DEF,
	parameter int MAX_FIELD_BITS = bfsr_pkg::MAX_FIELD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  bfsr_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bfsr_pkg::rsp_item_t rsp
);

	bfsr_pkg::ctl_t ctl;
	bfsr_pkg::st_t  st;

	bfsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.ctl       (ctl)
	);

	bfsr_dp #(
		.STORE_BYTES    (STORE_BYTES),
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.st     (st),
		.rsp    (rsp)
	);

endmodule

// File: tb/sv/bit_field_stream_reader_core_test.sv
`timescale 1ns / 100ps

module bit_field_stream_reader_core_test;

	localparam int CAP_BITS = bfsr_pkg::STORE_BYTES_DEF * 8;
	localparam int STALL_LIMIT = 20000;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_ready;
	bfsr_pkg::cmd_item_t cmd;
	logic                rsp_valid;
	logic                rsp_ready;
	bfsr_pkg::rsp_item_t rsp;

	bit_field_stream_reader_core dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// shadow copy of the bit store
	logic [CAP_BITS-1:0] shadow_bits;
	int unsigned         shadow_len, shadow_cur, shadow_mark;
	bfsr_pkg::rsp_item_t expected_rsps[$];
	int                  error_count = 0;
	bit                  idle_on;
	bit                  hold_rsp;
	bit                  hold_done;
	int                  quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] field_at(int unsigned pos, int unsigned n);
		logic [63:0] v;
		v = '0;
		for (int unsigned i = 0; i < n; i++)
			v = {v[62:0], shadow_bits[pos + i]};
		return v;
	endfunction

	function automatic bfsr_pkg::rsp_item_t predict_stream(bfsr_pkg::cmd_item_t c);
		bfsr_pkg::rsp_item_t r;
		int unsigned         n, left;
		logic [63:0]         raw, top, mag;
		r = '0;
		n = 32'(c.bit_count);
		left = shadow_len - shadow_cur;
		case (c.command)
			bfsr_pkg::CMD_APPEND: begin
				if (n == 0)
					r.ok = 1'b1;
				else if (n <= 8 && n <= CAP_BITS - shadow_len) begin
					for (int unsigned i = 0; i < n; i++)
						shadow_bits[shadow_len + i] = c.data_byte[7 - i];
					shadow_len += n;
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_READ_U: begin
				if (n == 0)
					r.ok = 1'b1;
				else if (n <= bfsr_pkg::MAX_FIELD_BITS_DEF && n <= left) begin
					r.value = field_at(shadow_cur, n);
					shadow_cur += n;
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_READ_S: begin
				if (n >= 2 && n <= bfsr_pkg::MAX_FIELD_BITS_DEF && n <= left &&
				    c.sign_format != bfsr_pkg::FMT_INVALID) begin
					raw = field_at(shadow_cur, n);
					top = 64'd1 << (n - 1);
					mag = raw & (top - 64'd1);
					if (c.sign_format == bfsr_pkg::FMT_SIGN_MAG)
						r.value = (raw & top) != 0 ? -mag : mag;
					else if (c.sign_format == bfsr_pkg::FMT_ONES)
						r.value = (raw & top) != 0 ? -((~raw) & (top - 64'd1)) : raw;
					else
						r.value = (raw ^ top) - top;
					shadow_cur += n;
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_READ_RUN: begin
				if (n != 0 && left != 0) begin
					r.run_bit = shadow_bits[shadow_cur];
					do begin
						r.run_length++;
						shadow_cur++;
					end while (r.run_length < n && shadow_cur < shadow_len &&
						shadow_bits[shadow_cur] == r.run_bit);
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_SKIP: begin
				if (n <= left) begin
					shadow_cur += n;
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_PEEK: begin
				if (left != 0) begin
					r.run_bit = shadow_bits[shadow_cur];
					r.ok = 1'b1;
				end
			end
			bfsr_pkg::CMD_MARK: begin
				shadow_mark = shadow_cur;
				r.ok = 1'b1;
			end
			bfsr_pkg::CMD_REW_MARK: begin
				r.rewound_bits = 16'(shadow_cur - shadow_mark);
				shadow_cur = shadow_mark;
				r.ok = 1'b1;
			end
			bfsr_pkg::CMD_REW_START: begin
				shadow_cur = 0;
				shadow_mark = 0;
				r.ok = 1'b1;
			end
			bfsr_pkg::CMD_CLEAR: begin
				shadow_len = 0;
				shadow_cur = 0;
				shadow_mark = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.cursor_position = 16'(shadow_cur);
		r.remaining_bits = 16'(shadow_len - shadow_cur);
		return r;
	endfunction

	// valid stays up across back-to-back beats; drop it only for an idle burst
	task automatic send_raw(bfsr_pkg::cmd_item_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		expected_rsps.push_back(predict_stream(c));
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic send_beat(bfsr_pkg::cmd_e op, logic [7:0] data, logic [15:0] count,
	                         bfsr_pkg::fmt_e fmt);
		bfsr_pkg::cmd_item_t c;
		c.command = op;
		c.data_byte = data;
		c.bit_count = count;
		c.sign_format = fmt;
		send_raw(c);
	endtask

	// response side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(posedge clk);
			end else
				rsp_ready <= 1'b1;
		end
	end

	// compare each response beat with the oldest prediction
	always @(posedge clk) begin
		bfsr_pkg::rsp_item_t e;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response beat %h", $time, rsp);
				error_count++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp !== e) begin
					$display("%0t: mismatch expected %h actual %h", $time, e, rsp);
					error_count++;
				end
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("bit_field_stream_reader_core_test: errors");
			$finish;
		end
	end

	task automatic append_random(int n);
		repeat (n) send_beat(bfsr_pkg::CMD_APPEND, 8'($urandom), 16'($urandom_range(1, 8)),
		                     bfsr_pkg::FMT_TWOS);
	endtask

	task automatic test_directed;
		send_beat(bfsr_pkg::CMD_PEEK, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_RUN, 8'h00, 16'd5, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_APPEND, 8'hFF, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_APPEND, 8'hFF, 16'd9, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_APPEND, 8'hFF, 16'hFFFF, bfsr_pkg::FMT_INVALID);
		send_beat(bfsr_pkg::CMD_APPEND, 8'h80, 16'd8, bfsr_pkg::FMT_SIGN_MAG);
		repeat (8) send_beat(bfsr_pkg::CMD_APPEND, 8'hFF, 16'd8, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_MARK, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_U, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_U, 8'h00, 16'd65, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_S, 8'h00, 16'd1, bfsr_pkg::FMT_TWOS);
		send_beat(bfsr_pkg::CMD_READ_S, 8'h00, 16'd8, bfsr_pkg::FMT_INVALID);
		send_beat(bfsr_pkg::CMD_READ_S, 8'h00, 16'd8, bfsr_pkg::FMT_SIGN_MAG); // negative zero
		send_beat(bfsr_pkg::CMD_REW_MARK, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_S, 8'h00, 16'd64, bfsr_pkg::FMT_ONES);
		send_beat(bfsr_pkg::CMD_REW_MARK, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_U, 8'h00, 16'd64, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_SKIP, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_SKIP, 8'h00, 16'd100, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_RUN, 8'h00, 16'hFFFF, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_REW_START, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_S, 8'h00, 16'd64, bfsr_pkg::FMT_TWOS);
		send_beat(bfsr_pkg::cmd_e'(4'd15), 8'hFF, 16'hFFFF, bfsr_pkg::FMT_INVALID);
		send_beat(bfsr_pkg::CMD_CLEAR, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
	endtask

	task automatic test_long_run;
		// a run spanning many stored bytes, then a run cut short by its limit
		repeat (60) send_beat(bfsr_pkg::CMD_APPEND, 8'hFF, 16'd8, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_APPEND, 8'h00, 16'd3, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_RUN, 8'h00, 16'hFFFF, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_READ_RUN, 8'h00, 16'd2, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_PEEK, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
		send_beat(bfsr_pkg::CMD_CLEAR, 8'h00, 16'd0, bfsr_pkg::FMT_SIGN_MAG);
	endtask

	task automatic test_random(int n);
		bfsr_pkg::cmd_item_t c;
		int                  k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30) begin
				append_random(1);
				continue;
			end
			c.data_byte = 8'($urandom);
			c.sign_format = 2'($urandom);
			c.command = 4'($urandom_range(1, 9));
			if (k < 33)
				c.command = 4'($urandom_range(10, 15));
			if (shadow_len > CAP_BITS - 200)
				c.command = bfsr_pkg::CMD_CLEAR;
			c.bit_count = 16'($urandom_range(0, 66));
			if (k >= 95)
				c.bit_count = 16'($urandom);
			else if (c.command == bfsr_pkg::CMD_READ_RUN)
				c.bit_count = 16'($urandom_range(1, 40));
			send_raw(c);
		end
	endtask

	task automatic test_backpressure;
		hold_rsp = 1'b1;
		append_random(40);
		test_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		shadow_bits = '0;
		shadow_len = 0;
		shadow_cur = 0;
		shadow_mark = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_run();
		test_backpressure();
		test_random(650);
		idle_on = 1'b0;
		test_random(280);
		cmd_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("bit_field_stream_reader_core_test: clean");
		else
			$display("bit_field_stream_reader_core_test: errors");
		$finish;
	end

endmodule
